>>> hdl/ntl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the numeric text lexer.
// No dependencies; used by ntl_lex_decode and numeric_text_lexer_dfa.
package ntl_pkg;

   typedef logic [3:0] lex_code_type;
   typedef logic [7:0] char_type;

   // Lexer state codes, as reported on the result channel
   localparam lex_code_type ST_WS       = 4'd0;
   localparam lex_code_type ST_SIGN     = 4'd1;
   localparam lex_code_type ST_INT      = 4'd2;
   localparam lex_code_type ST_PERIOD   = 4'd3;
   localparam lex_code_type ST_FRAC     = 4'd4;
   localparam lex_code_type ST_E        = 4'd5;
   localparam lex_code_type ST_EXPSIGN  = 4'd6;
   localparam lex_code_type ST_EXP      = 4'd7;
   localparam lex_code_type ST_EOL      = 4'd8;
   localparam lex_code_type ST_LABEL    = 4'd9;
   localparam lex_code_type ST_LC_EOL   = 4'd10;
   localparam lex_code_type ST_LC_OTHER = 4'd11;

   // Parse modes
   localparam logic MODE_FIELD = 1'b0;
   localparam logic MODE_LINE  = 1'b1;

   // Character codes
   localparam char_type CH_NL     = 8'h0A;
   localparam char_type CH_TAB    = 8'h09;
   localparam char_type CH_CR     = 8'h0D;
   localparam char_type CH_SPACE  = 8'h20;
   localparam char_type CH_COLON  = 8'h3A;
   localparam char_type CH_PERIOD = 8'h2E;
   localparam char_type CH_LOW_E  = 8'h65;
   localparam char_type CH_UP_E   = 8'h45;
   localparam char_type CH_MINUS  = 8'h2D;
   localparam char_type CH_PLUS   = 8'h2B;
   localparam char_type CH_ZERO   = 8'h30;
   localparam char_type CH_NINE   = 8'h39;

   function automatic lex_code_type start_state(input logic mode);
      start_state = (mode == MODE_LINE) ? ST_LC_OTHER : ST_WS;
   endfunction

endpackage

>>> hdl/numeric_text_lexer_dfa.sv
`timescale 1ns / 1ps
// Numeric text lexer state machine: one text byte per request, one result per request.
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the result channel is not stalled; the next-state decode is combinational.
// Reset (synchronous, active high): parse mode field, lexer state whitespace, both stages empty.
// Depends on ntl_pkg and ntl_lex_decode.
module numeric_text_lexer_dfa (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ntl_pkg::char_type     req_byte_in,
   input  logic                  req_restart,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ntl_pkg::lex_code_type rsp_prior_state,
   output ntl_pkg::lex_code_type rsp_new_state,
   output logic                  rsp_line_end,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_parse_mode
);

   // input register stage
   logic                  in_valid_ff, in_valid_in;
   ntl_pkg::char_type     in_byte_ff;
   logic                  in_restart_ff;

   // result register stage
   logic                  out_valid_ff, out_valid_in;
   ntl_pkg::lex_code_type out_prior_ff;
   ntl_pkg::lex_code_type out_next_ff;
   logic                  out_line_end_ff;

   // architectural state
   logic                  mode_ff, mode_in;
   ntl_pkg::lex_code_type state_ff, state_in;

   logic                  req_accept;
   logic                  out_open;
   logic                  advance;
   ntl_pkg::lex_code_type prior_state;
   ntl_pkg::lex_code_type nxt_state;
   logic                  nxt_line_end;
   logic                  mode_write;

   // The result register frees up when empty or when its result is taken this cycle;
   // the input register moves forward whenever the result register is open.
   assign out_open   = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_open;
   assign req_stall  = in_valid_ff && !out_open;
   assign req_accept = req_valid && !req_stall;

   // Configuration is always taken; software writes it only while the block is idle (not enforced by the block).
   assign csr_ready  = 1'b1;
   assign mode_write = csr_valid && (csr_parse_mode != mode_ff);

   // Restart loads the start state of the current mode before the byte is consumed.
   assign prior_state = in_restart_ff ? ntl_pkg::start_state(mode_ff) : state_ff;

   ntl_lex_decode u_next (
      .cur_state (prior_state),
      .char_code (in_byte_ff),
      .mode      (mode_ff),
      .nxt_state (nxt_state),
      .line_end  (nxt_line_end)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // A mode change resets the lexer to the new mode's start state.
      mode_in  = mode_ff;
      state_in = state_ff;
      if (mode_write) begin
         mode_in  = csr_parse_mode;
         state_in = ntl_pkg::start_state(csr_parse_mode);
      end else if (advance) begin
         state_in = nxt_state;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= ntl_pkg::MODE_FIELD;
         state_ff     <= ntl_pkg::ST_WS;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         state_ff     <= state_in;
      end
   end

   // payload: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff    <= req_byte_in;
         in_restart_ff <= req_restart;
      end
      if (advance) begin
         out_prior_ff    <= prior_state;
         out_next_ff     <= nxt_state;
         out_line_end_ff <= nxt_line_end;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_prior_state = out_prior_ff;
   assign rsp_new_state   = out_next_ff;
   assign rsp_line_end    = out_line_end_ff;

endmodule

>>> hdl/ntl_next_state.sv
`timescale 1ns / 1ps
// Next-state decode of the lexer: byte classes and the per-state transition table.
// Depends on ntl_pkg.
module ntl_lex_decode (
   input  ntl_pkg::lex_code_type cur_state,
   input  ntl_pkg::char_type     char_code,
   input  logic                  mode,
   output ntl_pkg::lex_code_type nxt_state,
   output logic                  line_end
);

   logic dig, blank, nl, colon, pm, ee, minus, period;

   always_comb begin
      dig    = (char_code >= ntl_pkg::CH_ZERO) && (char_code <= ntl_pkg::CH_NINE);
      blank  = (char_code == ntl_pkg::CH_SPACE) || (char_code == ntl_pkg::CH_TAB) ||
               (char_code == ntl_pkg::CH_CR);
      nl     = (char_code == ntl_pkg::CH_NL);
      colon  = (char_code == ntl_pkg::CH_COLON);
      minus  = (char_code == ntl_pkg::CH_MINUS);
      pm     = minus || (char_code == ntl_pkg::CH_PLUS);
      ee     = (char_code == ntl_pkg::CH_LOW_E) || (char_code == ntl_pkg::CH_UP_E);
      period = (char_code == ntl_pkg::CH_PERIOD);
   end

   always_comb begin
      unique case (cur_state)
         ntl_pkg::ST_WS: begin
            if (dig)                 nxt_state = ntl_pkg::ST_INT;
            else if (pm)             nxt_state = ntl_pkg::ST_SIGN;
            else if (blank || colon) nxt_state = ntl_pkg::ST_WS;
            else if (nl)             nxt_state = ntl_pkg::ST_EOL;
            else                     nxt_state = ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_SIGN, ntl_pkg::ST_PERIOD, ntl_pkg::ST_EXPSIGN: begin
            if (dig) begin
               if (cur_state == ntl_pkg::ST_SIGN)        nxt_state = ntl_pkg::ST_INT;
               else if (cur_state == ntl_pkg::ST_PERIOD) nxt_state = ntl_pkg::ST_FRAC;
               else                                      nxt_state = ntl_pkg::ST_EXP;
            end
            else if (blank) nxt_state = ntl_pkg::ST_WS;
            else if (nl)    nxt_state = ntl_pkg::ST_EOL;
            else            nxt_state = ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_INT: begin
            if (dig)                 nxt_state = ntl_pkg::ST_INT;
            else if (period)         nxt_state = ntl_pkg::ST_PERIOD;
            else if (ee)             nxt_state = ntl_pkg::ST_E;
            else if (blank || colon) nxt_state = ntl_pkg::ST_WS;
            else if (nl)             nxt_state = ntl_pkg::ST_EOL;
            else                     nxt_state = ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_FRAC: begin
            if (dig)                 nxt_state = ntl_pkg::ST_FRAC;
            else if (ee)             nxt_state = ntl_pkg::ST_E;
            else if (blank || colon) nxt_state = ntl_pkg::ST_WS;
            else if (nl)             nxt_state = ntl_pkg::ST_EOL;
            else                     nxt_state = ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_E: begin
            if (dig)        nxt_state = ntl_pkg::ST_EXP;
            else if (pm)    nxt_state = ntl_pkg::ST_EXPSIGN;
            else if (blank) nxt_state = ntl_pkg::ST_WS;
            else if (nl)    nxt_state = ntl_pkg::ST_EOL;
            else            nxt_state = ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_EXP: begin
            if (dig)                 nxt_state = ntl_pkg::ST_EXP;
            else if (blank || colon) nxt_state = ntl_pkg::ST_WS;
            else if (nl)             nxt_state = ntl_pkg::ST_EOL;
            else                     nxt_state = ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_EOL: begin
            if (dig)        nxt_state = ntl_pkg::ST_INT;
            else if (minus) nxt_state = ntl_pkg::ST_SIGN;
            else if (nl)    nxt_state = ntl_pkg::ST_EOL;
            else if (blank) nxt_state = ntl_pkg::ST_WS;
            else            nxt_state = ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_LABEL: begin
            if (nl)                  nxt_state = ntl_pkg::ST_EOL;
            else if (blank || colon) nxt_state = ntl_pkg::ST_WS;
            else                     nxt_state = ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_LC_EOL, ntl_pkg::ST_LC_OTHER: begin
            nxt_state = nl ? ntl_pkg::ST_LC_EOL : ntl_pkg::ST_LC_OTHER;
         end
         // unreachable codes fall back to the mode's start state
         default: nxt_state = ntl_pkg::start_state(mode);
      endcase
   end

   assign line_end = (nxt_state == ntl_pkg::ST_EOL) || (nxt_state == ntl_pkg::ST_LC_EOL);

endmodule

>>> verif/tb_numeric_text_lexer_dfa.sv
`timescale 1ns / 1ps
// Self-checking testbench for the numeric text lexer state machine.
// Depends on ntl_pkg and numeric_text_lexer_dfa; predicts every result in-line.
module tb_numeric_text_lexer_dfa;

   localparam int CLK_HALF    = 4;
   localparam int CYCLE_LIMIT = 200000;
   // two register stages inside the block; leave a little margin
   localparam int SETTLE_CYCLES = 4;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct packed {
      ntl_pkg::lex_code_type prior;
      ntl_pkg::lex_code_type next;
      logic                  line_end;
   } lex_result_type;

   typedef struct packed {
      row_kind_type          kind;
      logic                  mode;     // CFG rows only
      ntl_pkg::char_type     ch;
      logic                  restart;
      bit                    typed;    // expected result spelled out in the row
      ntl_pkg::lex_code_type prior;
      ntl_pkg::lex_code_type next;
      logic                  line_end;
   } stim_row_type;

   localparam int DIR_ROWS = 30;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   ntl_pkg::char_type     req_byte_in = '0;
   logic                  req_restart = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   ntl_pkg::lex_code_type rsp_prior_state;
   ntl_pkg::lex_code_type rsp_new_state;
   logic                  rsp_line_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_parse_mode = 1'b0;

   // predictor copy of the block's mode register and lexer state
   logic                  model_mode = ntl_pkg::MODE_FIELD;
   ntl_pkg::lex_code_type model_state = ntl_pkg::ST_WS;

   lex_result_type        pending_results[$];
   lex_result_type        oldest_result;
   lex_result_type        no_typed = '0;
   stim_row_type          dir_rows [DIR_ROWS];

   int                    err_count = 0;
   int                    cycle_count = 0;
   int                    send_idle_pct = 0;
   int                    rsp_stall_pct = 0;

   numeric_text_lexer_dfa DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_in     (req_byte_in),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prior_state (rsp_prior_state),
      .rsp_new_state   (rsp_new_state),
      .rsp_line_end    (rsp_line_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_parse_mode  (csr_parse_mode)
   );

   always #(CLK_HALF) clock = ~clock;

   // Start state of each mode: whitespace for fields, "other" for line counting.
   function automatic ntl_pkg::lex_code_type mode_home(input logic mode);
      if (mode == ntl_pkg::MODE_LINE) return ntl_pkg::ST_LC_OTHER;
      return ntl_pkg::ST_WS;
   endfunction

   // One step of the lexer table. Bytes a field-mode state does not list fall to label.
   function automatic ntl_pkg::lex_code_type lex_advance(input ntl_pkg::lex_code_type s,
                                                         input ntl_pkg::char_type c,
                                                         input logic mode);
      bit dig;
      bit blank;
      bit nl;
      bit colon;
      bit pm;
      bit ee;
      dig   = (c >= ntl_pkg::CH_ZERO) && (c <= ntl_pkg::CH_NINE);
      blank = (c == ntl_pkg::CH_SPACE) || (c == ntl_pkg::CH_TAB) || (c == ntl_pkg::CH_CR);
      nl    = (c == ntl_pkg::CH_NL);
      colon = (c == ntl_pkg::CH_COLON);
      pm    = (c == ntl_pkg::CH_PLUS) || (c == ntl_pkg::CH_MINUS);
      ee    = (c == ntl_pkg::CH_LOW_E) || (c == ntl_pkg::CH_UP_E);
      case (s)
         ntl_pkg::ST_WS: begin
            if (dig) return ntl_pkg::ST_INT;
            if (pm) return ntl_pkg::ST_SIGN;
            if (blank || colon) return ntl_pkg::ST_WS;
            if (nl) return ntl_pkg::ST_EOL;
            return ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_SIGN, ntl_pkg::ST_PERIOD, ntl_pkg::ST_EXPSIGN: begin
            // colon is not listed here, so it lands in label
            if (dig) begin
               if (s == ntl_pkg::ST_SIGN) return ntl_pkg::ST_INT;
               if (s == ntl_pkg::ST_PERIOD) return ntl_pkg::ST_FRAC;
               return ntl_pkg::ST_EXP;
            end
            if (blank) return ntl_pkg::ST_WS;
            if (nl) return ntl_pkg::ST_EOL;
            return ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_INT: begin
            if (dig) return ntl_pkg::ST_INT;
            if (c == ntl_pkg::CH_PERIOD) return ntl_pkg::ST_PERIOD;
            if (ee) return ntl_pkg::ST_E;
            if (blank || colon) return ntl_pkg::ST_WS;
            if (nl) return ntl_pkg::ST_EOL;
            return ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_FRAC: begin
            if (dig) return ntl_pkg::ST_FRAC;
            if (ee) return ntl_pkg::ST_E;
            if (blank || colon) return ntl_pkg::ST_WS;
            if (nl) return ntl_pkg::ST_EOL;
            return ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_E: begin
            if (dig) return ntl_pkg::ST_EXP;
            if (pm) return ntl_pkg::ST_EXPSIGN;
            if (blank) return ntl_pkg::ST_WS;
            if (nl) return ntl_pkg::ST_EOL;
            return ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_EXP: begin
            if (dig) return ntl_pkg::ST_EXP;
            if (blank || colon) return ntl_pkg::ST_WS;
            if (nl) return ntl_pkg::ST_EOL;
            return ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_EOL: begin
            // only minus starts a signed number after end of line; plus goes to label
            if (dig) return ntl_pkg::ST_INT;
            if (c == ntl_pkg::CH_MINUS) return ntl_pkg::ST_SIGN;
            if (nl) return ntl_pkg::ST_EOL;
            if (blank) return ntl_pkg::ST_WS;
            return ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_LABEL: begin
            if (nl) return ntl_pkg::ST_EOL;
            if (blank || colon) return ntl_pkg::ST_WS;
            return ntl_pkg::ST_LABEL;
         end
         ntl_pkg::ST_LC_EOL, ntl_pkg::ST_LC_OTHER: begin
            if (nl) return ntl_pkg::ST_LC_EOL;
            return ntl_pkg::ST_LC_OTHER;
         end
         default: return mode_home(mode);
      endcase
   endfunction

   function automatic ntl_pkg::char_type rand_digit();
      return ntl_pkg::char_type'(ntl_pkg::CH_ZERO + $urandom_range(9));
   endfunction

   function automatic ntl_pkg::char_type rand_term();
      case ($urandom_range(4))
         0: return ntl_pkg::CH_SPACE;
         1: return ntl_pkg::CH_TAB;
         2: return ntl_pkg::CH_CR;
         3: return ntl_pkg::CH_COLON;
         default: return ntl_pkg::CH_NL;
      endcase
   endfunction

   // Receiver side: stall at random with the current pressure setting.
   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // Result checker: compare each accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: prior=%0d new=%0d line_end=%0b",
                     $time, rsp_prior_state, rsp_new_state, rsp_line_end);
            err_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_prior_state !== oldest_result.prior) begin
               $display("%0t: prior_state expected %0d actual %0d",
                        $time, oldest_result.prior, rsp_prior_state);
               err_count++;
            end
            if (rsp_new_state !== oldest_result.next) begin
               $display("%0t: new state expected %0d actual %0d",
                        $time, oldest_result.next, rsp_new_state);
               err_count++;
            end
            if (rsp_line_end !== oldest_result.line_end) begin
               $display("%0t: line_end expected %0b actual %0b",
                        $time, oldest_result.line_end, rsp_line_end);
               err_count++;
            end
         end
      end
   end

   // Watchdog: end the run with errors once the cycle limit is reached.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Drop valid and hold until every predicted result has drained out.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Drive one request, hold it until accepted, then advance the predictor.
   // Call and return just after a rising edge.
   task automatic send_byte(input ntl_pkg::char_type ch, input logic rs, input bit typed,
                            input lex_result_type typed_res);
      lex_result_type res;
      logic           stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= ch;
      req_restart <= rs;
      // stall is settled by the falling edge; that value decides the next rising edge
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      if (rs) model_state = mode_home(model_mode);
      res.prior    = model_state;
      res.next     = lex_advance(model_state, ch, model_mode);
      res.line_end = (res.next == ntl_pkg::ST_EOL) || (res.next == ntl_pkg::ST_LC_EOL);
      model_state  = res.next;
      pending_results.insert(pending_results.size(), typed ? typed_res : res);
   endtask

   // Write the mode register with the block idle. A real change reloads the start state.
   task automatic write_mode(input logic m);
      logic rdy;
      settle_pipeline();
      csr_valid      <= 1'b1;
      csr_parse_mode <= m;
      do begin
         @(negedge clock);
         rdy = csr_ready;
         @(posedge clock);
      end while (!rdy);
      csr_valid <= 1'b0;
      if (m != model_mode) begin
         model_mode  = m;
         model_state = mode_home(m);
      end
   endtask

   // Random traffic in one mode. Field mode is mostly well-formed number and
   // label tokens with random content; the rest is raw noise and terminator pairs.
   task automatic run_random(input logic m, input int n_items);
      ntl_pkg::char_type chunk[$];
      int                sent;
      int                r;
      int                nd;
      sent = 0;
      write_mode(m);
      while (sent < n_items) begin
         chunk.delete();
         r = $urandom_range(99);
         if (m == ntl_pkg::MODE_LINE) begin
            if (r < 30) chunk.insert(chunk.size(), ntl_pkg::CH_NL);
            else chunk.insert(chunk.size(), ntl_pkg::char_type'($urandom_range(255)));
         end else if (r < 60) begin
            // number: [sign] [digits] [. [digits]] [e [sign] digits] terminator
            if ($urandom_range(1)) begin
               chunk.insert(chunk.size(),
                            $urandom_range(1) ? ntl_pkg::CH_MINUS : ntl_pkg::CH_PLUS);
            end
            nd = $urandom_range(4);
            repeat (nd) chunk.insert(chunk.size(), rand_digit());
            if ($urandom_range(99) < 40) begin
               chunk.insert(chunk.size(), ntl_pkg::CH_PERIOD);
               nd = $urandom_range(3);
               repeat (nd) chunk.insert(chunk.size(), rand_digit());
            end
            if ($urandom_range(99) < 30) begin
               chunk.insert(chunk.size(),
                            $urandom_range(1) ? ntl_pkg::CH_LOW_E : ntl_pkg::CH_UP_E);
               if ($urandom_range(1)) begin
                  chunk.insert(chunk.size(),
                               $urandom_range(1) ? ntl_pkg::CH_MINUS : ntl_pkg::CH_PLUS);
               end
               nd = 1 + $urandom_range(1);
               repeat (nd) chunk.insert(chunk.size(), rand_digit());
            end
            chunk.insert(chunk.size(), rand_term());
         end else if (r < 75) begin
            nd = 1 + $urandom_range(3);
            repeat (nd) begin
               chunk.insert(chunk.size(), ntl_pkg::char_type'(8'h61 + $urandom_range(25)));
            end
            chunk.insert(chunk.size(), rand_term());
         end else if (r < 90) begin
            chunk.insert(chunk.size(), ntl_pkg::char_type'($urandom_range(255)));
         end else begin
            chunk.insert(chunk.size(), rand_term());
            chunk.insert(chunk.size(), rand_term());
         end
         foreach (chunk[j]) begin
            // pause now and then until the block has drained completely
            if (sent == n_items / 2 || $urandom_range(49) == 0) settle_pipeline();
            send_byte(chunk[j], $urandom_range(99) < 3, 1'b0, no_typed);
            sent++;
         end
      end
   endtask

   initial begin
      lex_result_type typed_res;

      // kind, mode, byte, restart, typed, prior, next, line_end
      dir_rows = '{
         '{ROW_REQ, 1'b0, 8'h00, 1'b0, 1'b1, ntl_pkg::ST_WS, ntl_pkg::ST_LABEL, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_NL, 1'b0, 1'b1, ntl_pkg::ST_LABEL, ntl_pkg::ST_EOL, 1'b1},
         // plus after end of line is not a sign
         '{ROW_REQ, 1'b0, ntl_pkg::CH_PLUS, 1'b0, 1'b1, ntl_pkg::ST_EOL, ntl_pkg::ST_LABEL, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_COLON, 1'b1, 1'b1, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_MINUS, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         // colon after a sign
         '{ROW_REQ, 1'b0, ntl_pkg::CH_COLON, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_SPACE, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_NINE, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_PERIOD, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         // colon after a period
         '{ROW_REQ, 1'b0, ntl_pkg::CH_COLON, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         // restart, then a number with an exponent mark
         '{ROW_REQ, 1'b0, ntl_pkg::CH_ZERO, 1'b1, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_PERIOD, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_ZERO, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_UP_E, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         // colon after the exponent mark
         '{ROW_REQ, 1'b0, ntl_pkg::CH_COLON, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, 8'hFF, 1'b1, 1'b1, ntl_pkg::ST_WS, ntl_pkg::ST_LABEL, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_CR, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_NINE, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_LOW_E, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_PLUS, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         // colon after the exponent sign
         '{ROW_REQ, 1'b0, ntl_pkg::CH_COLON, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         // same mode again: state must be kept
         '{ROW_CFG, ntl_pkg::MODE_FIELD, 8'h00, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_NL, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         // colon after end of line
         '{ROW_REQ, 1'b0, ntl_pkg::CH_COLON, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_CFG, ntl_pkg::MODE_LINE, 8'h00, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, 8'hFF, 1'b0, 1'b1, ntl_pkg::ST_LC_OTHER, ntl_pkg::ST_LC_OTHER, 1'b0},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_NL, 1'b0, 1'b1,
           ntl_pkg::ST_LC_OTHER, ntl_pkg::ST_LC_EOL, 1'b1},
         '{ROW_REQ, 1'b0, ntl_pkg::CH_NL, 1'b1, 1'b1,
           ntl_pkg::ST_LC_OTHER, ntl_pkg::ST_LC_EOL, 1'b1},
         '{ROW_CFG, ntl_pkg::MODE_FIELD, 8'h00, 1'b0, 1'b0, ntl_pkg::ST_WS, ntl_pkg::ST_WS, 1'b0},
         '{ROW_REQ, 1'b0, 8'h80, 1'b0, 1'b1, ntl_pkg::ST_WS, ntl_pkg::ST_LABEL, 1'b0}
      };

      send_idle_pct = 31;
      rsp_stall_pct = 67;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            write_mode(dir_rows[i].mode);
         end else begin
            typed_res.prior    = dir_rows[i].prior;
            typed_res.next     = dir_rows[i].next;
            typed_res.line_end = dir_rows[i].line_end;
            send_byte(dir_rows[i].ch, dir_rows[i].restart, dir_rows[i].typed, typed_res);
         end
      end

      // random traffic under three pressure settings
      run_random(ntl_pkg::MODE_FIELD, 170);
      run_random(ntl_pkg::MODE_LINE, 45);
      send_idle_pct = 67;
      rsp_stall_pct = 31;
      run_random(ntl_pkg::MODE_FIELD, 170);
      run_random(ntl_pkg::MODE_LINE, 45);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random(ntl_pkg::MODE_FIELD, 170);
      run_random(ntl_pkg::MODE_LINE, 45);

      // drain, then allow the pipeline depth for any stray result
      settle_pipeline();
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> numeric_text_lexer_dfa.f
hdl/ntl_pkg.sv
hdl/ntl_next_state.sv
hdl/numeric_text_lexer_dfa.sv
verif/tb_numeric_text_lexer_dfa.sv
